### rtl/base64_lenient_decoder_core_macros.svh
// Assertion macros for the lenient Base64 decoder.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef BASE64_LENIENT_DECODER_CORE_MACROS_SVH
`define BASE64_LENIENT_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define B64LD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64ld check failed: same-cycle rule");

// Next-cycle implication, checked out of reset.
`define B64LD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64ld check failed: next-cycle rule");

`endif

### rtl/b64ld_pkg.sv
// Shared types, constants and the symbol mapping of the lenient Base64 decoder.
// No dependencies; used by the decode logic, the top level and the testbench.
package b64ld_pkg;

    localparam int unsigned CountWidth = 24;
    localparam logic [CountWidth-1:0] COUNT_MAX = 24'hFF_FFFF;
    localparam logic [CountWidth-1:0] CAPACITY_RESET = 24'hFF_FFFF;

    // Configuration port geometry
    localparam int unsigned AddrWidth = 3;
    localparam logic REG_CAPACITY = 1'b0;

    // Position of a symbol within its group of four
    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;
    localparam logic [1:0] PHASE_FOURTH = 2'd3;

    typedef logic [CountWidth-1:0] count_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sym_t;

    // Result of one character applied to the group state
    typedef struct packed {
        logic       have_byte;
        logic [7:0] data;
        logic [1:0] phase_next;
        logic [5:0] partial_next;
    } step_t;

    // Map a raw character to its 6-bit symbol; both alphabets are accepted.
    function automatic sym_t symbol_of(input logic [7:0] ch);
        sym_t       s;
        logic [7:0] d;
        s = '{valid: 1'b0, value: 6'd0};
        d = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            d = ch - 8'h41;
            s = '{valid: 1'b1, value: d[5:0]};
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            d = ch - 8'h61 + 8'd26;
            s = '{valid: 1'b1, value: d[5:0]};
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            d = ch - 8'h30 + 8'd52;
            s = '{valid: 1'b1, value: d[5:0]};
        end
        else if (ch == 8'h2B || ch == 8'h2D)
        begin
            s = '{valid: 1'b1, value: 6'd62};
        end
        else if (ch == 8'h2F || ch == 8'h5F)
        begin
            s = '{valid: 1'b1, value: 6'd63};
        end
        return s;
    endfunction

endpackage

### rtl/b64ld_in_if.sv
// Character channel of the lenient Base64 decoder: valid/ready plus payload.
// Depends on nothing else.
interface b64ld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

### rtl/b64ld_out_if.sv
// Result channel of the lenient Base64 decoder: valid/ready plus payload.
// Depends on nothing else.
interface b64ld_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        within_buffer;
    logic [23:0] bytes_decoded;
    logic        text_done;

    modport source (output valid, output data_byte, output byte_valid,
                    output within_buffer, output bytes_decoded, output text_done,
                    input ready);
    modport sink (input valid, input data_byte, input byte_valid,
                  input within_buffer, input bytes_decoded, input text_done,
                  output ready);
endinterface

### rtl/b64ld_decode.sv
// Symbol mapping and byte assembly for one character of the Base64 text.
// Depends on b64ld_pkg for the symbol function, phase codes and step_t.
module b64ld_decode
(
    input  logic [7:0]        ch,
    input  logic [1:0]        phase,
    input  logic [5:0]        partial,
    output b64ld_pkg::step_t  step
);

    b64ld_pkg::sym_t sym;

    assign sym = b64ld_pkg::symbol_of(ch);

    // Place the new symbol's bits against those left over from the group
    always_comb
    begin
        step.have_byte    = 1'b0;
        step.data         = 8'd0;
        step.phase_next   = phase;
        step.partial_next = partial;
        if (sym.valid)
        begin
            step.phase_next = phase + 2'd1;
            case (phase)
                b64ld_pkg::PHASE_FIRST:
                begin
                    step.partial_next = sym.value;
                end
                b64ld_pkg::PHASE_SECOND:
                begin
                    step.have_byte    = 1'b1;
                    step.data         = {partial, sym.value[5:4]};
                    step.partial_next = {2'b00, sym.value[3:0]};
                end
                b64ld_pkg::PHASE_THIRD:
                begin
                    step.have_byte    = 1'b1;
                    step.data         = {partial[3:0], sym.value[5:2]};
                    step.partial_next = {4'b0000, sym.value[1:0]};
                end
                b64ld_pkg::PHASE_FOURTH:
                begin
                    step.have_byte    = 1'b1;
                    step.data         = {partial[1:0], sym.value};
                    step.partial_next = 6'd0;
                end
                default:
                begin
                    step.partial_next = partial;
                end
            endcase
        end
    end

endmodule

### rtl/base64_lenient_decoder_core.sv
// Lenient Base64 decoder top level: input stage, group state, byte counter, result register.
// Depends on b64ld_pkg, b64ld_in_if, b64ld_out_if, b64ld_decode and the macros header.
//
// Usage:
//   text    : one character word per handshake (text_char, end_of_text).
//   result  : one word for each character that completes a byte or ends the text;
//             characters outside both Base64 alphabets, padding included, give none unless they end the text.
//   APB     : buffer_capacity at byte address 0, written when psel, penable, pwrite
//             and pready are high; write it only while the decoder is idle.
// Path: an accepted character is held in the input register, and its result is
//   loaded into the result register when the character leaves the input register.
// Throughput: one character per cycle while no stall holds the input register; the
//   symbol decode and the 24-bit count compare and increment are combinational between the two registers.
// Reset: group position, partial bits and byte count go to zero and the capacity
//   to 0xFFFFFF; both registers are empty.
// Stall: while the result register is full and not taken, a character that would
//   give a result waits in the input register and text.ready falls; characters
//   giving no result still pass through and update the group state.
`include "base64_lenient_decoder_core_macros.svh"

module base64_lenient_decoder_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b64ld_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    b64ld_in_if.sink                         text,
    b64ld_out_if.source                      result
);

    // Configuration register
    b64ld_pkg::count_t capacity_reg;
    b64ld_pkg::count_t capacity_next;

    // Input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_eot_reg;

    // Group and count state
    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [5:0]        partial_reg;
    logic [5:0]        partial_next;
    b64ld_pkg::count_t count_reg;
    b64ld_pkg::count_t count_next;

    // Result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_data_reg;
    logic              out_byte_reg;
    logic              out_fits_reg;
    b64ld_pkg::count_t out_count_reg;
    logic              out_done_reg;

    b64ld_pkg::step_t  step;
    logic              emit;
    logic              out_free;
    logic              s1_go;
    logic              accept;
    logic              cfg_write;
    logic              fits;
    b64ld_pkg::count_t count_inc;

    // APB access: always ready, one register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[b64ld_pkg::AddrWidth-1] == b64ld_pkg::REG_CAPACITY);
    assign capacity_next = cfg_write ? pwdata[b64ld_pkg::CountWidth-1:0] : capacity_reg;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[b64ld_pkg::AddrWidth-1] == b64ld_pkg::REG_CAPACITY)
        begin
            prdata = {8'd0, capacity_reg};
        end
    end

    // Decode the held character against the group state
    b64ld_decode u_decode
    (
        .ch      (s1_char_reg),
        .phase   (phase_reg),
        .partial (partial_reg),
        .step    (step)
    );

    // Handshake between the input register and the result register
    assign emit     = step.have_byte || s1_eot_reg;
    assign out_free = !out_valid_reg || result.ready;
    assign s1_go    = s1_valid_reg && (out_free || !emit);
    assign text.ready = !s1_valid_reg || s1_go;
    assign accept   = text.valid && text.ready;
    assign s1_valid_next = accept || (s1_valid_reg && !s1_go);

    // Byte index check and saturating count
    assign fits      = count_reg < capacity_reg;
    assign count_inc = (step.have_byte && (count_reg != b64ld_pkg::COUNT_MAX))
                       ? count_reg + b64ld_pkg::count_t'(1) : count_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        if (s1_go)
        begin
            if (s1_eot_reg)
            begin
                phase_next   = b64ld_pkg::PHASE_FIRST;
                partial_next = 6'd0;
                count_next   = '0;
            end
            else
            begin
                phase_next   = step.phase_next;
                partial_next = step.partial_next;
                count_next   = count_inc;
            end
        end
    end

    assign out_valid_next = (s1_go && emit) ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= b64ld_pkg::CAPACITY_RESET;
            s1_valid_reg  <= 1'b0;
            phase_reg     <= b64ld_pkg::PHASE_FIRST;
            partial_reg   <= 6'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_char_reg <= text.text_char;
            s1_eot_reg  <= text.end_of_text;
        end
        if (s1_go && emit)
        begin
            out_data_reg  <= step.have_byte ? step.data : 8'd0;
            out_byte_reg  <= step.have_byte;
            out_fits_reg  <= step.have_byte && fits;
            out_count_reg <= count_inc;
            out_done_reg  <= s1_eot_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.data_byte     = out_data_reg;
    assign result.byte_valid    = out_byte_reg;
    assign result.within_buffer = out_fits_reg;
    assign result.bytes_decoded = out_count_reg;
    assign result.text_done     = out_done_reg;

    // Checks on the decoder's own behaviour
    `B64LD_ASSERT_NOW(a_word_has_cause, out_valid_reg, out_byte_reg || out_done_reg)
    `B64LD_ASSERT_NOW(a_fits_needs_byte, out_valid_reg && out_fits_reg, out_byte_reg)
    `B64LD_ASSERT_NOW(a_no_byte_zero_data, out_valid_reg && !out_byte_reg, out_data_reg == 8'd0)
    `B64LD_ASSERT_NEXT(a_end_clears, s1_go && s1_eot_reg,
        phase_reg == b64ld_pkg::PHASE_FIRST && partial_reg == 6'd0 && count_reg == '0)

endmodule

### bench/base64_lenient_decoder_core_test.sv
// Self-checking testbench for the lenient Base64 decoder core.
// Depends on b64ld_pkg, b64ld_in_if, b64ld_out_if and base64_lenient_decoder_core.
`timescale 1ns / 1ps

module base64_lenient_decoder_core_test;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1150;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam logic [b64ld_pkg::AddrWidth-1:0] CAPACITY_ADDR =
        b64ld_pkg::AddrWidth'(4 * b64ld_pkg::REG_CAPACITY);

    // One result word as seen on the result channel.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               byte_valid;
        logic               within_buffer;
        b64ld_pkg::count_t  bytes_decoded;
        logic               text_done;
    } decoded_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [b64ld_pkg::AddrWidth-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    b64ld_in_if  text_ch ();
    b64ld_out_if result_ch ();

    base64_lenient_decoder_core u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text    (text_ch),
        .result  (result_ch)
    );

    // Mirror of the decoder state and its capacity register.
    logic [1:0]         group_phase;
    logic [5:0]         leftover_bits;
    b64ld_pkg::count_t  decoded_total;
    b64ld_pkg::count_t  capacity_setting;

    decoded_word_t decoded_words_due[$];
    int unsigned   error_count;
    int unsigned   sent_items;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left;
    bit            text_gaps_on;
    bit            result_stalls_on;

    always #5 clk = ~clk;

    // Own mapping from a character to a 6-bit symbol; bit 6 marks a valid symbol.
    function automatic logic [6:0] char_symbol(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'd0;
        if (ch >= "A" && ch <= "Z")
            v = ch - "A";
        else if (ch >= "a" && ch <= "z")
            v = ch - "a" + 8'd26;
        else if (ch >= "0" && ch <= "9")
            v = ch - "0" + 8'd52;
        else if (ch == "+" || ch == "-")
            v = 8'd62;
        else if (ch == "/" || ch == "_")
            v = 8'd63;
        else
            return 7'd0;
        return {1'b1, v[5:0]};
    endfunction

    // Advance the mirrored state by one character and queue any result it causes.
    function automatic void decode_char(input logic [7:0] ch, input logic eot);
        logic [6:0]    sym;
        decoded_word_t word;
        sym = char_symbol(ch);
        word = '0;
        if (sym[6])
        begin
            case (group_phase)
                b64ld_pkg::PHASE_FIRST:
                begin
                    leftover_bits = sym[5:0];
                end
                b64ld_pkg::PHASE_SECOND:
                begin
                    word.data_byte = {leftover_bits, sym[5:4]};
                    leftover_bits = {2'b00, sym[3:0]};
                    word.byte_valid = 1'b1;
                end
                b64ld_pkg::PHASE_THIRD:
                begin
                    word.data_byte = {leftover_bits[3:0], sym[5:2]};
                    leftover_bits = {4'b0000, sym[1:0]};
                    word.byte_valid = 1'b1;
                end
                default:
                begin
                    word.data_byte = {leftover_bits[1:0], sym[5:0]};
                    leftover_bits = 6'd0;
                    word.byte_valid = 1'b1;
                end
            endcase
            group_phase = group_phase + 2'd1;
        end
        if (word.byte_valid)
        begin
            word.within_buffer = decoded_total < capacity_setting;
            if (decoded_total != b64ld_pkg::COUNT_MAX)
                decoded_total = decoded_total + 1'b1;
        end
        if (!word.byte_valid && !eot)
            return;
        word.bytes_decoded = decoded_total;
        word.text_done = eot;
        decoded_words_due.push_back(word);
        if (eot)
        begin
            group_phase = b64ld_pkg::PHASE_FIRST;
            leftover_bits = 6'd0;
            decoded_total = '0;
        end
    endfunction

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 7) : 0;
    endfunction

    // A random character from either alphabet.
    function automatic logic [7:0] random_symbol_char();
        int unsigned s;
        s = $urandom_range(0, 63);
        if (s < 26)
            return 8'(s) + "A";
        if (s < 52)
            return 8'(s - 26) + "a";
        if (s < 62)
            return 8'(s - 52) + "0";
        if (s == 62)
            return $urandom_range(0, 1) ? "+" : "-";
        return $urandom_range(0, 1) ? "/" : "_";
    endfunction

    // Send one character word, with a random gap before it, and predict it on acceptance.
    task automatic send_char(input logic [7:0] ch, input logic eot);
        int unsigned gap;
        gap = draw_wait(text_gaps_on);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid <= 1'b1;
        text_ch.text_char <= ch;
        text_ch.end_of_text <= eot;
        do
            @(posedge clk);
        while (!(text_ch.valid && text_ch.ready));
        sent_items++;
        decode_char(ch, eot);
    endtask

    task automatic send_string(input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_last && (i == s.len() - 1));
    endtask

    // Stop sending and wait until the decoder has nothing left in flight.
    task automatic settle();
        text_ch.valid <= 1'b0;
        while (decoded_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_transfer(input logic wr, input logic [b64ld_pkg::AddrWidth-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Write the capacity while idle and read it back.
    task automatic set_capacity(input b64ld_pkg::count_t value);
        logic [31:0] rdata;
        settle();
        apb_transfer(1'b1, CAPACITY_ADDR, {8'h00, value}, rdata);
        capacity_setting = value;
        @(posedge clk);
        apb_transfer(1'b0, CAPACITY_ADDR, 32'd0, rdata);
        if (rdata[23:0] !== value)
        begin
            $display("%0t: capacity read back: expected %h, actual %h", $time, value,
                     rdata[23:0]);
            error_count++;
        end
    endtask

    task automatic send_random_text(input int unsigned max_len);
        int unsigned len;
        len = $urandom_range(0, max_len);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_char($urandom_range(0, 1) ? "=" : 8'($urandom_range(0, 255)), 1'b0);
            else
                send_char(random_symbol_char(), 1'b0);
        end
        // The last character may be a symbol, padding or any byte at all.
        case ($urandom_range(0, 3))
            0: send_char("=", 1'b1);
            1: send_char(8'($urandom_range(0, 255)), 1'b1);
            default: send_char(random_symbol_char(), 1'b1);
        endcase
    endtask

    // Both alphabets at their edges, skipped characters and the three ways a text ends.
    task automatic test_directed();
        text_gaps_on = 1'b1;
        result_stalls_on = 1'b1;
        send_string("AZaz09+-/_", 1'b0);
        send_char(8'h3D, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_string("@[{:", 1'b0);
        send_char(8'h60, 1'b0);
        send_char("Q", 1'b0);
        // End on padding with partial bits pending: no byte, count reported.
        send_char("=", 1'b1);
        // A text holding nothing but its end.
        send_char("=", 1'b1);
        // End on the character that completes a byte.
        send_string("TWFu", 1'b1);
        settle();
    endtask

    // Bytes beyond the capacity are flagged as not stored.
    task automatic test_capacity();
        b64ld_pkg::count_t caps[5];
        caps = '{24'd0, 24'd1, 24'd4, 24'hFF_FFFE, b64ld_pkg::COUNT_MAX};
        foreach (caps[i])
        begin
            set_capacity(caps[i]);
            for (int j = 0; j < 12; j++)
                send_char(random_symbol_char(), 1'b0);
            send_char(random_symbol_char(), 1'b1);
        end
        settle();
    endtask

    // Full-rate texts with no idling on either side.
    task automatic test_back_to_back();
        text_gaps_on = 1'b0;
        result_stalls_on = 1'b0;
        repeat (4) send_random_text(30);
        settle();
    endtask

    // Random texts with random capacities and idling patterns.
    task automatic test_random();
        int unsigned start_items;
        start_items = sent_items;
        while (sent_items - start_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: set_capacity('0);
                    1: set_capacity(b64ld_pkg::COUNT_MAX);
                    2: set_capacity(b64ld_pkg::count_t'($urandom_range(0, 40)));
                    default: set_capacity(b64ld_pkg::count_t'($urandom));
                endcase
            end
            text_gaps_on = $urandom_range(0, 3) != 0;
            result_stalls_on = $urandom_range(0, 3) != 0;
            send_random_text($urandom_range(0, 7) == 0 ? 60 : 24);
        end
        settle();
    endtask

    // Result side: random stalls, and each accepted word checked against the oldest due.
    always @(posedge clk)
    begin
        decoded_word_t due;
        decoded_word_t got;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = draw_wait(result_stalls_on);
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = '{data_byte: result_ch.data_byte, byte_valid: result_ch.byte_valid,
                        within_buffer: result_ch.within_buffer,
                        bytes_decoded: result_ch.bytes_decoded,
                        text_done: result_ch.text_done};
                if (decoded_words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h", $time, got);
                    error_count++;
                end
                else
                begin
                    due = decoded_words_due.pop_front();
                    if (got.data_byte !== due.data_byte)
                        $display("%0t: data_byte: expected %h, actual %h", $time,
                                 due.data_byte, got.data_byte);
                    if (got.byte_valid !== due.byte_valid)
                        $display("%0t: byte_valid: expected %b, actual %b", $time,
                                 due.byte_valid, got.byte_valid);
                    if (got.within_buffer !== due.within_buffer)
                        $display("%0t: within_buffer: expected %b, actual %b", $time,
                                 due.within_buffer, got.within_buffer);
                    if (got.bytes_decoded !== due.bytes_decoded)
                        $display("%0t: bytes_decoded: expected %h, actual %h", $time,
                                 due.bytes_decoded, got.bytes_decoded);
                    if (got.text_done !== due.text_done)
                        $display("%0t: text_done: expected %b, actual %b", $time,
                                 due.text_done, got.text_done);
                    if (got !== due)
                        error_count++;
                end
                stall_left = draw_wait(result_stalls_on);
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("base64_lenient_decoder_core_test failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        text_ch.valid <= 1'b0;
        text_ch.text_char <= 8'd0;
        text_ch.end_of_text <= 1'b0;
        group_phase = b64ld_pkg::PHASE_FIRST;
        leftover_bits = 6'd0;
        decoded_total = '0;
        capacity_setting = b64ld_pkg::CAPACITY_RESET;
        error_count = 0;
        sent_items = 0;
        text_gaps_on = 1'b1;
        result_stalls_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_back_to_back();
        test_random();
        set_capacity(b64ld_pkg::COUNT_MAX);
        settle();

        if (error_count == 0)
            $display("base64_lenient_decoder_core_test passed");
        else
            $display("base64_lenient_decoder_core_test failed");
        $finish;
    end

endmodule
